// File: src/huffman_bit_packer_assert.svh
// Assertion macros used by the packer RTL (hbp_packer).
// Depends on nothing; each use names its own clock and active-low reset.
`ifndef HUFFMAN_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define HBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define HBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/hbp_pkg.sv
// Package for the Huffman bit packer: widths, request codes, shared types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package hbp_pkg;

	localparam int ALPHABET      = 128;
	localparam int SYM_W         = $clog2(ALPHABET);
	localparam int MAX_CODE_BITS = 32;
	localparam int LEN_W         = 6;
	localparam int CODE_W        = 32;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_ENCODE = 1'b1;

	localparam logic [SYM_W-1:0] END_SYMBOL = '0;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} hbp_entry_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
		logic              stream_end;
	} hbp_job_t;

	typedef enum logic [1:0] {
		HBP_IDLE,
		HBP_LOOKUP,
		HBP_PACK
	} hbp_state_t;

endpackage

`default_nettype wire

// File: src/hbp_code_table.sv
// Code table: one synchronous memory of length and code bits per symbol.
// Depends on hbp_pkg; lengths read as zero until an entry is loaded.
`default_nettype none

module hbp_code_table (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic [hbp_pkg::SYM_W-1:0] wr_addr,
	input  wire logic [hbp_pkg::LEN_W-1:0] wr_len,
	input  wire logic [hbp_pkg::CODE_W-1:0] wr_bits,
	input  wire logic                     rd_en,
	input  wire logic [hbp_pkg::SYM_W-1:0] rd_addr,
	output hbp_pkg::hbp_entry_t           rd_entry
);
	import hbp_pkg::*;

	hbp_entry_t              mem [ALPHABET];
	logic [ALPHABET-1:0]     valid_q;
	hbp_entry_t              rd_data_q;
	logic                    rd_hit_q;
	logic [LEN_W-1:0]        sat_len;
	logic [CODE_W:0]         mask_wide;
	hbp_entry_t              wr_entry;

	// Bits beyond the code length are stored as zero so the packer can OR freely.
	always_comb begin
		sat_len = (wr_len > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS) : wr_len;
		mask_wide = ((CODE_W+1)'(1) << sat_len) - (CODE_W+1)'(1);
		wr_entry.len = sat_len;
		wr_entry.code = wr_bits & mask_wide[CODE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_hit_q <= valid_q[rd_addr];
		end
	end

	always_comb begin
		rd_entry.len = rd_hit_q ? rd_data_q.len : '0;
		rd_entry.code = rd_hit_q ? rd_data_q.code : '0;
	end

endmodule

`default_nettype wire

// File: src/hbp_packer.sv
// Bit accumulator and byte emitter with a registered output stage.
// Depends on hbp_pkg and huffman_bit_packer_assert.svh.
`default_nettype none

module hbp_packer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire hbp_pkg::hbp_job_t job,
	output logic            busy,
	output logic            byte_valid,
	input  wire logic       byte_ready,
	output logic [7:0]      out_byte,
	output logic            last,
	output logic            stream_end
);
	import hbp_pkg::*;

	logic              busy_q;
	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0]  rem_q;
	logic              end_q;
	logic [6:0]        pending_q;
	logic [2:0]        count_q;
	logic              valid_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic              stream_end_q;

	logic              can_step;
	logic [LEN_W:0]    total;
	logic              emit_full;
	logic              emit_flush;
	logic [3:0]        take;
	logic [CODE_W+7:0] merged;

	always_comb begin
		can_step = busy_q && (!valid_q || byte_ready);
		total = {{(LEN_W-2){1'b0}}, count_q} + {1'b0, rem_q};
		emit_full = (total >= (LEN_W+1)'(8));
		emit_flush = !emit_full && end_q;
		take = 4'd8 - {1'b0, count_q};
		merged = {{(CODE_W+1){1'b0}}, pending_q} | ({8'b0, code_q} << count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			code_q <= '0;
			rem_q <= '0;
			end_q <= 1'b0;
			pending_q <= '0;
			count_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			code_q <= job.code;
			rem_q <= job.len;
			end_q <= job.stream_end;
		end else if (can_step) begin
			if (emit_full) begin
				code_q <= code_q >> take;
				rem_q <= rem_q - {{(LEN_W-4){1'b0}}, take};
				pending_q <= '0;
				count_q <= '0;
			end else begin
				busy_q <= 1'b0;
				rem_q <= '0;
				if (end_q) begin
					pending_q <= '0;
					count_q <= '0;
				end else begin
					pending_q <= merged[6:0];
					count_q <= total[2:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_step && (emit_full || emit_flush)) begin
			valid_q <= 1'b1;
		end else if (byte_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_step && (emit_full || emit_flush)) begin
			byte_q <= emit_full ? merged[7:0] : {1'b0, merged[6:0]};
			last_q <= emit_flush || (total < (LEN_W+1)'(16) && !end_q);
			stream_end_q <= emit_flush;
		end
	end

	assign busy = busy_q;
	assign byte_valid = valid_q;
	assign out_byte = byte_q;
	assign last = last_q;
	assign stream_end = stream_end_q;

	`include "huffman_bit_packer_assert.svh"

	`HBP_ASSERT_NOW(a_start_when_free, clk, arst_n, start, !busy_q, "job started while busy")
	`HBP_ASSERT_NOW(a_end_is_last, clk, arst_n, valid_q && stream_end_q, last_q, "stream end without last")
	`HBP_ASSERT_NEXT(a_flush_clears, clk, arst_n, can_step && emit_flush, (count_q == 3'd0) && !busy_q, "flush left bits pending")
	`HBP_ASSERT_NEXT(a_full_emits, clk, arst_n, can_step && emit_full, valid_q && busy_q, "full byte not presented")

endmodule

`default_nettype wire

// File: src/huffman_bit_packer.sv
// Top level of the Huffman bit packer: request sequencer, code table, packer.
// Depends on hbp_pkg, hbp_code_table and hbp_packer.
//
//   channel  | handshake               | payload
//   request  | req_valid / req_ready   | req_type, symbol, code_len, code_bits
//   bytes    | byte_valid / byte_ready | out_byte, last, stream_end
//
// A table load is a single write to the table memory. An encode is accepted, the table
// memory is read, the packer emits each full byte, then parks leftover bits or emits the
// flush byte, and the sequencer then returns to idle.
// Reset clears the table length valid bits at once; no clearing pass is needed.
// A stalled byte channel holds the packer; requests wait until the packer is free.
`default_nettype none

module huffman_bit_packer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire logic                      req_type,
	input  wire logic [hbp_pkg::SYM_W-1:0]  symbol,
	input  wire logic [hbp_pkg::LEN_W-1:0]  code_len,
	input  wire logic [hbp_pkg::CODE_W-1:0] code_bits,
	output logic                           byte_valid,
	input  wire logic                      byte_ready,
	output logic [7:0]                     out_byte,
	output logic                           last,
	output logic                           stream_end
);
	import hbp_pkg::*;

	hbp_state_t state_q;
	hbp_state_t state_next;
	logic       accept;
	logic       do_load;
	logic       do_encode;
	logic       end_s1;
	logic       start;
	logic       busy;
	hbp_entry_t entry;
	hbp_job_t   job;

	assign accept = req_valid && req_ready;
	assign do_load = accept && (req_type == REQ_LOAD);
	assign do_encode = accept && (req_type == REQ_ENCODE);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			HBP_IDLE: begin
				if (do_encode) begin
					state_next = HBP_LOOKUP;
				end
			end
			HBP_LOOKUP: begin
				state_next = HBP_PACK;
			end
			HBP_PACK: begin
				if (!busy) begin
					state_next = HBP_IDLE;
				end
			end
			default: begin
				state_next = HBP_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = (state_q == HBP_IDLE);
		start = (state_q == HBP_LOOKUP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HBP_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (do_encode) begin
			end_s1 <= (symbol == END_SYMBOL);
		end
	end

	always_comb begin
		job.len = entry.len;
		job.code = entry.code;
		job.stream_end = end_s1;
	end

	hbp_code_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (do_load),
		.wr_addr  (symbol),
		.wr_len   (code_len),
		.wr_bits  (code_bits),
		.rd_en    (do_encode),
		.rd_addr  (symbol),
		.rd_entry (entry)
	);

	hbp_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.job        (job),
		.busy       (busy),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.out_byte   (out_byte),
		.last       (last),
		.stream_end (stream_end)
	);

endmodule

`default_nettype wire
